[src/rfrc_pkg.sv]
// ----------------------------------------------------------------------------
// rfrc_pkg
// Shared types, constants and the CRC-8 function of the repetition frame
// receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package rfrc_pkg;

  localparam int unsigned CopiesDefault = 3;

  localparam int unsigned ThresholdW = 8;
  localparam int unsigned TimeoutW   = 16;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [ThresholdW-1:0] ThresholdReset = 8'd127;
  localparam logic [TimeoutW-1:0]   TimeoutReset   = 16'd200;

  localparam logic [7:0] CrcPoly   = 8'h07;
  localparam logic [7:0] ReplyAck  = 8'd65;
  localparam logic [7:0] ReplyNack = 8'd78;

  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_TICK = 1'b1
  } rfrc_func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_TIMEOUT   = 1'b1
  } rfrc_cfg_e;

  typedef struct packed {
    logic [7:0] decoded_byte;
    logic [7:0] rx_crc;
    logic [7:0] calc_crc;
    logic       crc_ok;
    logic [7:0] reply_byte;
  } rfrc_result_t;

  function automatic logic [7:0] crc8(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/rfrc_decode.sv]
// ----------------------------------------------------------------------------
// rfrc_decode
// Majority vote over the per-bit counts, CRC-8 of the decoded byte and the
// comparison with the received CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module rfrc_decode
  import rfrc_pkg::*;
#(
  parameter int unsigned COPIES = CopiesDefault
) (
  input  logic [7:0][$clog2(COPIES+1)-1:0] votes_i,
  input  logic [7:0]                       crc_byte_i,
  output rfrc_result_t                     result_o
);

  localparam int unsigned VoteW = $clog2(COPIES + 1);
  localparam logic [VoteW-1:0] Half = VoteW'(COPIES / 2);

  logic [7:0] dec;
  logic [7:0] crc;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      dec[7-i] = (votes_i[i] > Half);
    end
  end

  assign crc = crc8(dec);

  always_comb begin
    result_o.decoded_byte = dec;
    result_o.rx_crc       = crc_byte_i;
    result_o.calc_crc     = crc;
    result_o.crc_ok       = (crc == crc_byte_i);
    result_o.reply_byte   = (crc == crc_byte_i) ? ReplyAck : ReplyNack;
  end

endmodule

`default_nettype wire

[src/repetition_frame_receiver_crc8.sv]
// ----------------------------------------------------------------------------
// repetition_frame_receiver_crc8
// Repetition-coded frame receiver: votes each data bit over its copies,
// checks CRC-8 of the decoded byte against the trailing CRC byte.
// ----------------------------------------------------------------------------
//   channel  direction  handshake                  fields
//   in       input      in_valid_i / in_stall_o    func_i, data_byte_i
//   out      output     out_valid_o / out_stall_i  decoded_byte_o, rx_crc_o,
//                                                  calc_crc_o, crc_ok_o, reply_byte_o
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle while in_stall_o is low; a frame result is registered
// when its CRC byte is accepted. Frame state updates at the accepting edge.
// An output register plus a skid register; in_stall_o rises only while the
// skid register holds a result. Reset clears frame state, config to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module repetition_frame_receiver_crc8
  import rfrc_pkg::*;
#(
  parameter int unsigned COPIES = CopiesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [7:0]           data_byte_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           decoded_byte_o,
  output logic [7:0]           rx_crc_o,
  output logic [7:0]           calc_crc_o,
  output logic                 crc_ok_o,
  output logic [7:0]           reply_byte_o
);

  localparam int unsigned SampleBytes = COPIES * 8;
  localparam int unsigned CountW      = $clog2(SampleBytes + 1);
  localparam int unsigned VoteW       = $clog2(COPIES + 1);
  localparam logic [CountW-1:0] LastCount = CountW'(SampleBytes);

  logic [ThresholdW-1:0] threshold_q;
  logic [TimeoutW-1:0]   timeout_q;

  logic [CountW-1:0]           byte_cnt_q, byte_cnt_d;
  logic [TimeoutW-1:0]         idle_q, idle_d;
  logic [7:0][VoteW-1:0]       votes_q, votes_d;

  rfrc_result_t res, out_q, skid_q;
  logic         out_valid_q, skid_valid_q;
  logic         in_acc, res_valid, out_pop;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign out_pop    = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
      timeout_q   <= TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (rfrc_cfg_e'(cfg_idx_i))
        CFG_THRESHOLD: threshold_q <= cfg_wdata_i[ThresholdW-1:0];
        CFG_TIMEOUT:   timeout_q   <= cfg_wdata_i[TimeoutW-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    byte_cnt_d = byte_cnt_q;
    idle_d     = idle_q;
    votes_d    = votes_q;
    res_valid  = 1'b0;
    if (in_acc) begin
      if (func_i == FUNC_TICK) begin
        if (byte_cnt_q != '0) begin
          if (idle_q >= timeout_q) begin
            byte_cnt_d = '0;
            idle_d     = '0;
            votes_d    = '0;
          end else begin
            idle_d = idle_q + TimeoutW'(1);
          end
        end
      end else begin
        idle_d = '0;
        if (byte_cnt_q < LastCount) begin
          if (data_byte_i > threshold_q) begin
            votes_d[byte_cnt_q[2:0]] = votes_q[byte_cnt_q[2:0]] + VoteW'(1);
          end
          byte_cnt_d = byte_cnt_q + CountW'(1);
        end else begin
          res_valid  = 1'b1;
          byte_cnt_d = '0;
          votes_d    = '0;
        end
      end
    end
  end

  rfrc_decode #(
    .COPIES(COPIES)
  ) u_decode (
    .votes_i    (votes_q),
    .crc_byte_i (data_byte_i),
    .result_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      idle_q     <= '0;
      votes_q    <= '0;
    end else begin
      byte_cnt_q <= byte_cnt_d;
      idle_q     <= idle_d;
      votes_q    <= votes_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign decoded_byte_o = out_q.decoded_byte;
  assign rx_crc_o       = out_q.rx_crc;
  assign calc_crc_o     = out_q.calc_crc;
  assign crc_ok_o       = out_q.crc_ok;
  assign reply_byte_o   = out_q.reply_byte;

endmodule

`default_nettype wire
